// ===== rtl/lfbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfbs_pkg
// Shared types and constants for the LED fade and blink sequencer: item
// structs, action and register codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lfbs_pkg;

  // default fractional bits of the fade level
  localparam int LEVEL_FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] STEP_INTERVAL_RST = 16'd50;
  localparam logic [7:0]  FADE_STEPS_RST    = 8'd20;
  localparam logic [7:0]  BLINK_COUNT_RST   = 8'd3;
  localparam logic [15:0] BLINK_DELAY_RST   = 16'd300;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_INTERVAL = 2'd0,
    REG_FADE_STEPS    = 2'd1,
    REG_BLINK_COUNT   = 2'd2,
    REG_BLINK_DELAY   = 2'd3
  } cfg_reg_t;

  // item action codes
  typedef enum logic [1:0] {
    ACT_TIME  = 2'd0,
    ACT_FADE  = 2'd1,
    ACT_BLINK = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // input item
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [7:0]  target_level;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       pwm_write;
    logic [7:0] pwm_level;
    logic [7:0] brightness;
    logic       idle;
    logic       blink_done;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic eval;
    logic div_start;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_fade;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/lfbs_div.sv =====
// ----------------------------------------------------------------------------
// lfbs_div
// Restoring divider by an 8-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfbs_div #(
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [7:0]    divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [7:0]    rem;
  logic [7:0]    dsr;
  logic [8:0]    rem_sh;
  logic [8:0]    rem_sub;
  logic          fits;

  // one trial subtraction per cycle
  always_comb begin
    rem_sh  = {rem, quo[DW-1]};
    fits    = rem_sh >= {1'b0, dsr};
    rem_sub = rem_sh - {1'b0, dsr};
  end

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(DW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

  assign quotient = quo;
  assign done     = (cnt == '0);

endmodule

// ===== rtl/lfbs_dp.sv =====
// ----------------------------------------------------------------------------
// lfbs_dp
// Sequencer datapath: configuration registers, fade and blink state, elapsed
// time checks, increment divider, clamp and the registered result item.
// ----------------------------------------------------------------------------
module lfbs_dp #(
  parameter int LEVEL_FRAC_BITS = lfbs_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lfbs_pkg::in_item_t                 in_data,
  input  lfbs_pkg::cmd_t                     cmd,
  output lfbs_pkg::stat_t                    stat,
  input  logic                               cfg_we,
  input  logic [lfbs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [lfbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_ready,
  output lfbs_pkg::out_item_t                out_data
);

  localparam int F  = LEVEL_FRAC_BITS;
  localparam int LW = 8 + F;   // unsigned level
  localparam int IW = LW + 1;  // signed increment and difference
  localparam int SW = LW + 2;  // signed level plus increment
  localparam int DW = IW;      // divider dividend

  // configuration
  logic [15:0] step_interval_ms;
  logic [7:0]  fade_steps;
  logic [7:0]  blink_count;
  logic [15:0] blink_delay_ms;

  // animation state
  logic [LW-1:0]        fade_level;
  logic [7:0]           fade_target;
  logic signed [IW-1:0] fade_increment;
  logic [31:0]          fade_last_time;
  logic [31:0]          blink_last_time;
  logic                 blink_is_on;
  logic [7:0]           blink_counter;
  logic [7:0]           blink_on_level;

  logic [LW-1:0]        fade_level_next;
  logic [7:0]           fade_target_next;
  logic signed [IW-1:0] fade_increment_next;
  logic [31:0]          fade_last_time_next;
  logic [31:0]          blink_last_time_next;
  logic                 blink_is_on_next;
  logic [7:0]           blink_counter_next;
  logic [7:0]           blink_on_level_next;

  // item and evaluation registers
  lfbs_pkg::in_item_t   item;
  logic                 ev_blink_el;
  logic                 ev_fade_el;
  logic signed [SW-1:0] ev_sum;
  logic signed [IW-1:0] ev_diff;

  logic                 blink_fin;
  logic                 fade_fin;
  logic [31:0]          blink_age;
  logic [31:0]          fade_age;
  logic signed [SW-1:0] sum_c;
  logic signed [IW-1:0] diff_c;
  logic [DW-1:0]        diff_mag;
  logic [7:0]           steps_eff;
  logic [DW-1:0]        div_dividend;
  logic [DW-1:0]        div_quot;
  logic                 div_done;
  logic signed [SW-1:0] tgt_fx;
  logic signed [SW-1:0] clamped;
  lfbs_pkg::out_item_t  res;

  // finished tests on the current state
  assign blink_fin = (blink_counter == blink_count) && blink_is_on;
  assign fade_fin  = (fade_level[LW-1 -: 8] == fade_target);

  // elapsed time, level step and fade difference
  always_comb begin
    blink_age = item.now_ms - blink_last_time;
    fade_age  = item.now_ms - fade_last_time;
    sum_c     = $signed({2'b00, fade_level}) +
                $signed({{(SW-IW){fade_increment[IW-1]}}, fade_increment});
    diff_c    = $signed({1'b0, item.target_level, {F{1'b0}}}) -
                $signed({1'b0, fade_level});
  end

  // capture item and evaluation results
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.eval) begin
      ev_blink_el <= blink_age >= {16'd0, blink_delay_ms};
      ev_fade_el  <= fade_age >= {16'd0, step_interval_ms};
      ev_sum      <= sum_c;
      ev_diff     <= diff_c;
    end
  end

  // rounded-up increment magnitude: (|diff| + steps - 1) / steps
  always_comb begin
    diff_mag     = ev_diff[IW-1] ? DW'(-ev_diff) : DW'(ev_diff);
    steps_eff    = (fade_steps == 8'd0) ? 8'd1 : fade_steps;
    div_dividend = diff_mag + {{(DW-8){1'b0}}, steps_eff - 8'd1};
  end

  lfbs_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (steps_eff),
    .quotient (div_quot),
    .done     (div_done)
  );

  // clamp the stepped level at the target
  always_comb begin
    tgt_fx = $signed({2'b00, fade_target, {F{1'b0}}});
    if (fade_increment[IW-1]) begin
      clamped = (ev_sum < tgt_fx) ? tgt_fx : ev_sum;
    end else begin
      clamped = (ev_sum > tgt_fx) ? tgt_fx : ev_sum;
    end
  end

  // next state and result of the current item
  always_comb begin
    fade_level_next      = fade_level;
    fade_target_next     = fade_target;
    fade_increment_next  = fade_increment;
    fade_last_time_next  = fade_last_time;
    blink_last_time_next = blink_last_time;
    blink_is_on_next     = blink_is_on;
    blink_counter_next   = blink_counter;
    blink_on_level_next  = blink_on_level;
    res                  = '0;
    case (lfbs_pkg::action_t'(item.action))
      lfbs_pkg::ACT_FADE: begin
        fade_target_next    = item.target_level;
        fade_increment_next = ev_diff[IW-1] ? $signed(-div_quot) : $signed(div_quot);
        fade_last_time_next = item.now_ms;
      end
      lfbs_pkg::ACT_BLINK: begin
        if (blink_fin) begin
          blink_counter_next   = 8'd1;
          blink_on_level_next  = fade_level[LW-1 -: 8];
          blink_is_on_next     = 1'b0;
          blink_last_time_next = item.now_ms;
          res.pwm_write        = 1'b1;
        end
      end
      lfbs_pkg::ACT_TIME: begin
        if (!blink_fin) begin
          if (ev_blink_el) begin
            blink_is_on_next = !blink_is_on;
            res.pwm_write    = 1'b1;
            if (!blink_is_on) begin
              res.pwm_level = blink_on_level;
            end else begin
              blink_counter_next = blink_counter + 8'd1;
            end
            res.blink_done = (blink_counter_next == blink_count) && blink_is_on_next;
            blink_last_time_next = item.now_ms;
          end
        end else if (!fade_fin && ev_fade_el) begin
          fade_last_time_next = item.now_ms;
          fade_level_next     = clamped[LW-1:0];
          res.pwm_write       = 1'b1;
          res.pwm_level       = fade_level_next[LW-1 -: 8];
        end
      end
      default: begin
      end
    endcase
    res.brightness = fade_level_next[LW-1 -: 8];
    res.idle       = (blink_counter_next == blink_count) && blink_is_on_next &&
                     (fade_level_next[LW-1 -: 8] == fade_target_next);
  end

  // animation state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval_ms <= lfbs_pkg::STEP_INTERVAL_RST;
      fade_steps       <= lfbs_pkg::FADE_STEPS_RST;
      blink_count      <= lfbs_pkg::BLINK_COUNT_RST;
      blink_delay_ms   <= lfbs_pkg::BLINK_DELAY_RST;
      fade_level       <= '0;
      fade_target      <= '0;
      fade_increment   <= '0;
      fade_last_time   <= '0;
      blink_last_time  <= '0;
      blink_is_on      <= 1'b1;
      blink_counter    <= lfbs_pkg::BLINK_COUNT_RST;
      blink_on_level   <= '0;
    end else if (cmd.commit) begin
      fade_level      <= fade_level_next;
      fade_target     <= fade_target_next;
      fade_increment  <= fade_increment_next;
      fade_last_time  <= fade_last_time_next;
      blink_last_time <= blink_last_time_next;
      blink_is_on     <= blink_is_on_next;
      blink_counter   <= blink_counter_next;
      blink_on_level  <= blink_on_level_next;
    end else if (cfg_we) begin
      case (lfbs_pkg::cfg_reg_t'(cfg_idx))
        lfbs_pkg::REG_STEP_INTERVAL: step_interval_ms <= cfg_wdata;
        lfbs_pkg::REG_FADE_STEPS:    fade_steps       <= cfg_wdata[7:0];
        lfbs_pkg::REG_BLINK_COUNT: begin
          blink_count   <= cfg_wdata[7:0];
          blink_counter <= cfg_wdata[7:0];
        end
        lfbs_pkg::REG_BLINK_DELAY:   blink_delay_ms   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= res;
    end
  end

  // status to the controller
  assign stat.is_fade  = (lfbs_pkg::action_t'(item.action) == lfbs_pkg::ACT_FADE);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

  // a committed item is always presented
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed item not presented");

  // a start leaves the divider busy
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !div_done)
    else $error("divider finished straight after start");

endmodule

// ===== rtl/lfbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfbs_ctrl
// Sequencer controller: takes one item at a time, steps it through
// evaluation, the optional increment division and the commit.
// ----------------------------------------------------------------------------
module lfbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output lfbs_pkg::cmd_t   cmd,
  input  lfbs_pkg::stat_t  stat
);

  lfbs_pkg::state_t state;
  lfbs_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lfbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = lfbs_pkg::ST_EVAL;
        end
      end
      lfbs_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.is_fade ? lfbs_pkg::ST_PREP : lfbs_pkg::ST_FINISH;
      end
      lfbs_pkg::ST_PREP: begin
        cmd.div_start = 1'b1;
        state_next    = lfbs_pkg::ST_DIV;
      end
      lfbs_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = lfbs_pkg::ST_FINISH;
        end
      end
      lfbs_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = lfbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lfbs_pkg::ST_IDLE;
      end
    endcase
  end

  // the division is waited out
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == lfbs_pkg::ST_DIV) && !stat.div_done |=> (state == lfbs_pkg::ST_DIV))
    else $error("left division before it finished");

  // no commit over an unread result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit while output register is full");

endmodule

// ===== rtl/led_fade_and_blink_sequencer_top.sv =====
// Flow: one item at a time; time check and blink items pass through evaluation
//   and commit, fade items also through the divider (one quotient bit per divider
//   cycle). A new item is taken only once the last one is committed, and the commit
//   waits while the output is stalled.
// Reset: synchronous; registers return to their defaults and the animation state
//   to off and finished, with no pending result.
// ----------------------------------------------------------------------------
// led_fade_and_blink_sequencer_top
// LED brightness engine: fade to a target level in fixed-point steps and
// boundary blink at the captured level, sharing one PWM duty output.
// ----------------------------------------------------------------------------
module led_fade_and_blink_sequencer_top #(
  parameter int LEVEL_FRAC_BITS = lfbs_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lfbs_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lfbs_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [lfbs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lfbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  lfbs_pkg::cmd_t  cmd;
  lfbs_pkg::stat_t stat;

  // controller
  lfbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath
  lfbs_dp #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
